[hdl/cft_pkg.sv]
// cft_pkg: shared types and codes for the circular fifo with traverse
// request and result payloads, operation and status codes, cell control
// no dependencies
package cft_pkg;

	localparam int WORD_W = 32;

	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_TRAV = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [WORD_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [WORD_W-1:0]  data;
		logic                      last;
	} rsp_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_POP,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [WORD_W-1:0]  push_word;
		logic signed [WORD_W-1:0]  head_word;
	} cell_ctrl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_TRAV
	} fsm_t;

endpackage

[hdl/cft_stream_if.sv]
// cft_stream_if: valid/ready channel carrying one payload per request
// payload type is a parameter; used with cft_pkg::req_t and cft_pkg::rsp_t
interface cft_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[hdl/cft_cell.sv]
// cft_cell: one slot of the queue chain, holds a word and its valid bit
// shifts, fills or rotates with its neighbors; depends on cft_pkg
module cft_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cft_pkg::cell_ctrl_t                ctrl,
	input  logic                               prev_valid,
	input  logic                               next_valid,
	input  logic signed [cft_pkg::WORD_W-1:0]  next_word,
	output logic                               valid,
	output logic signed [cft_pkg::WORD_W-1:0]  word
);

	logic                               valid_q;
	logic signed [cft_pkg::WORD_W-1:0]  word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				cft_pkg::CELL_PUSH: begin
					if (!valid_q && prev_valid)
						valid_q <= 1'b1;
				end
				cft_pkg::CELL_POP: valid_q <= next_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			cft_pkg::CELL_PUSH: begin
				if (!valid_q && prev_valid)
					word_q <= ctrl.push_word;
			end
			cft_pkg::CELL_POP: word_q <= next_word;
			cft_pkg::CELL_ROT: begin
				if (valid_q)
					word_q <= next_valid ? next_word : ctrl.head_word;
			end
			default: word_q <= word_q;
		endcase
	end

	assign valid = valid_q;
	assign word  = word_q;

endmodule

[hdl/circular_fifo_with_traverse.sv]
// circular_fifo_with_traverse: fifo of DEPTH signed words with traverse
// built from a chain of cft_cell slots; depends on cft_pkg, cft_stream_if
//
// The queue is a row of DEPTH cells with the oldest word always in the first
// cell. Enqueue fills the first free cell, dequeue shifts every word one cell
// toward the front, and traverse rotates the row once per stored word so that
// each word in turn passes the front cell and goes out, leaving the order as
// it was. Enqueue and dequeue give one result each, the unused mode none;
// a traverse of n stored words holds the request side until its n results,
// one rotation step per result, have gone out, and each step waits while
// the result side stalls. Results leave through one output register, so a
// new request is taken while the previous result is being taken.
module circular_fifo_with_traverse #(
	parameter int DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	cft_stream_if.sink         req,
	cft_stream_if.source       rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cft_pkg::fsm_t        state_q, state_next;
	logic [CNT_W-1:0]     count_q, remain_q;
	logic                 rsp_valid_q;
	cft_pkg::rsp_t        rsp_q, rsp_next;
	logic                 emit;
	logic                 out_free;
	logic                 accept;
	cft_pkg::cell_ctrl_t  ctrl;

	logic                               cell_valid [DEPTH];
	logic signed [cft_pkg::WORD_W-1:0]  cell_word  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                               pv, nv;
		logic signed [cft_pkg::WORD_W-1:0]  nw;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
		end else begin : g_mid
			assign pv = cell_valid[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign nv = 1'b0;
			assign nw = '0;
		end else begin : g_inner
			assign nv = cell_valid[i+1];
			assign nw = cell_word[i+1];
		end
		cft_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (pv),
			.next_valid (nv),
			.next_word  (nw),
			.valid      (cell_valid[i]),
			.word       (cell_word[i])
		);
	end

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == cft_pkg::FSM_IDLE) && out_free;
	assign accept    = req.valid && req.ready;

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			cft_pkg::FSM_IDLE: begin
				if (accept && req.payload.mode == cft_pkg::MODE_TRAV && count_q != '0)
					state_next = cft_pkg::FSM_TRAV;
			end
			cft_pkg::FSM_TRAV: begin
				if (out_free && remain_q == CNT_W'(1))
					state_next = cft_pkg::FSM_IDLE;
			end
			default: state_next = cft_pkg::FSM_IDLE;
		endcase
	end

	// outputs and cell control
	always_comb begin
		emit           = 1'b0;
		rsp_next       = '0;
		rsp_next.last  = 1'b1;
		ctrl.op        = cft_pkg::CELL_HOLD;
		ctrl.push_word = req.payload.value;
		ctrl.head_word = cell_word[0];
		unique case (state_q)
			cft_pkg::FSM_IDLE: begin
				if (accept) begin
					case (req.payload.mode)
						cft_pkg::MODE_ENQ: begin
							emit = 1'b1;
							if (count_q == FULL_CNT) begin
								rsp_next.status = cft_pkg::STAT_FULL;
							end else begin
								rsp_next.status = cft_pkg::STAT_OK;
								rsp_next.data   = req.payload.value;
								ctrl.op         = cft_pkg::CELL_PUSH;
							end
						end
						cft_pkg::MODE_DEQ: begin
							emit = 1'b1;
							if (count_q == '0) begin
								rsp_next.status = cft_pkg::STAT_EMPTY;
							end else begin
								rsp_next.status = cft_pkg::STAT_OK;
								rsp_next.data   = cell_word[0];
								ctrl.op         = cft_pkg::CELL_POP;
							end
						end
						cft_pkg::MODE_TRAV: begin
							if (count_q == '0) begin
								emit            = 1'b1;
								rsp_next.status = cft_pkg::STAT_EMPTY;
							end
						end
						default: emit = 1'b0;
					endcase
				end
			end
			cft_pkg::FSM_TRAV: begin
				if (out_free) begin
					emit            = 1'b1;
					rsp_next.status = cft_pkg::STAT_OK;
					rsp_next.data   = cell_word[0];
					rsp_next.last   = (remain_q == CNT_W'(1));
					ctrl.op         = cft_pkg::CELL_ROT;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cft_pkg::FSM_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (ctrl.op == cft_pkg::CELL_PUSH)
				count_q <= count_q + CNT_W'(1);
			else if (ctrl.op == cft_pkg::CELL_POP)
				count_q <= count_q - CNT_W'(1);
			if (state_q == cft_pkg::FSM_IDLE)
				remain_q <= count_q;
			else if (emit)
				remain_q <= remain_q - CNT_W'(1);
			if (emit)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			rsp_q <= rsp_next;
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule
